FILE: rtl/fee_pkg.sv
`default_nettype none
package fee_pkg;

    localparam int TIME_W  = 24;
    localparam int RPM_W   = 16;
    localparam int AIR_W   = 16;
    localparam int ALT_W   = 16;
    localparam int FUEL_W  = 16;
    localparam int IAS_W   = 9;
    localparam int RUN_W   = 8;
    localparam int SUM_W   = 48;
    localparam int CNT_W   = 32;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;
    localparam int IAS_SHIFT = 7;

    // register indexes on the config port
    localparam logic [CIDX_W-1:0] CFG_RPM_THR = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_AIR_THR = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_LOOKBACK = 2'd2;

    localparam logic [RPM_W-1:0] RPM_THR_RST  = 16'd1000;
    localparam logic [IAS_W-1:0] AIR_THR_RST  = 9'd40;
    localparam logic [RUN_W-1:0] LOOKBACK_RST = 8'd5;

    localparam logic signed [ALT_W-1:0] ALT_LOW_INIT  = 16'sd10000;
    localparam logic signed [ALT_W-1:0] ALT_HIGH_INIT = 16'sd0;

    // op codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // event codes
    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_ON   = 2'd1;
    localparam logic [1:0] EV_OFF  = 2'd2;

    typedef struct packed {
        logic                     op;
        logic [TIME_W-1:0]        sample_seconds;
        logic [RPM_W-1:0]         engine_rpm;
        logic [AIR_W-1:0]         airspeed_raw;
        logic signed [ALT_W-1:0]  altitude;
        logic [FUEL_W-1:0]        fuel_flow_raw;
    } t_in;

    typedef struct packed {
        logic signed [ALT_W-1:0]  lowest_altitude;
        logic signed [ALT_W-1:0]  highest_altitude;
        logic [AIR_W-1:0]         top_airspeed_raw;
        logic [SUM_W-1:0]         fuel_flow_total;
        logic [CNT_W-1:0]         fuel_sample_count;
    } t_stats;

    typedef struct packed {
        logic [1:0]               engine_event;
        logic [TIME_W-1:0]        engine_event_seconds;
        logic [1:0]               flight_event;
        logic [TIME_W-1:0]        flight_event_seconds;
        logic signed [ALT_W-1:0]  lowest_altitude;
        logic signed [ALT_W-1:0]  highest_altitude;
        logic [AIR_W-1:0]         top_airspeed_raw;
        logic [SUM_W-1:0]         fuel_flow_total;
        logic [CNT_W-1:0]         fuel_sample_count;
    } t_out;

    // per-beat control into the state-holding units
    typedef struct packed {
        logic step;
        logic clr;
    } t_step_ctl;

    typedef struct packed {
        logic [1:0]        ev;
        logic [TIME_W-1:0] secs;
    } t_det_res;

endpackage
`default_nettype wire

FILE: rtl/flight_engine_event_detector.sv
`default_nettype none
// Channel | Handshake         | Payload          | Direction
// in      | i_valid / o_stall | i_in  (t_in)     | sample or clear op, into the block
// out     | o_valid / i_stall | o_out (t_out)    | one result per input beat
// cfg     | i_cfg_we          | i_cfg_idx, i_cfg_data | register write, no wait
//
// One beat per cycle sustained while the output is not stalled; a result goes
// through the input register, then detector/statistics update into the
// result register. State is updated as a beat moves into the result
// register, so the next beat sees it directly. Reset is synchronous and
// restores the valid flags, config registers and state. A held result
// stalls the pipe only when both registers are full.
module flight_engine_event_detector (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_valid,
    output logic                           o_stall,
    input  fee_pkg::t_in                   i_in,
    output logic                           o_valid,
    input  wire                            i_stall,
    output fee_pkg::t_out                  o_out,
    input  wire                            i_cfg_we,
    input  wire [fee_pkg::CIDX_W-1:0]      i_cfg_idx,
    input  wire [fee_pkg::CFG_W-1:0]       i_cfg_data
);
    import fee_pkg::*;

    logic [RPM_W-1:0] r_rpm_thr;
    logic [IAS_W-1:0] r_air_thr;
    logic [RUN_W-1:0] r_lookback;

    logic             r_in_valid;
    t_in              r_in;
    logic             r_out_valid;
    t_out             r_out;

    logic             advance;
    t_step_ctl        ctl;
    t_det_res         eng_res;
    t_det_res         flt_res;
    t_stats           stats;

    assign advance  = r_in_valid && (!r_out_valid || !i_stall);
    assign ctl.step = advance && (r_in.op == OP_SAMPLE);
    assign ctl.clr  = advance && (r_in.op == OP_CLEAR);
    assign o_stall  = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpm_thr  <= RPM_THR_RST;
            r_air_thr  <= AIR_THR_RST;
            r_lookback <= LOOKBACK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RPM_THR:  r_rpm_thr  <= i_cfg_data;
                CFG_AIR_THR:  r_air_thr  <= i_cfg_data[IAS_W-1:0];
                CFG_LOOKBACK: r_lookback <= i_cfg_data[RUN_W-1:0];
                default: ;
            endcase
        end
    end

    fee_detector u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_value    (r_in.engine_rpm),
        .i_thr      (r_rpm_thr),
        .i_lookback (r_lookback),
        .i_now      (r_in.sample_seconds),
        .o_res      (eng_res)
    );

    fee_detector u_flight (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_value    ({{(RPM_W-IAS_W){1'b0}}, r_in.airspeed_raw[AIR_W-1:IAS_SHIFT]}),
        .i_thr      ({{(RPM_W-IAS_W){1'b0}}, r_air_thr}),
        .i_lookback (r_lookback),
        .i_now      (r_in.sample_seconds),
        .o_res      (flt_res)
    );

    fee_stats u_stats (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_sample  (r_in),
        .i_rpm_thr (r_rpm_thr),
        .i_air_thr (r_air_thr),
        .o_stats   (stats)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_in;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.engine_event         <= eng_res.ev;
            r_out.engine_event_seconds <= eng_res.secs;
            r_out.flight_event         <= flt_res.ev;
            r_out.flight_event_seconds <= flt_res.secs;
            r_out.lowest_altitude      <= stats.lowest_altitude;
            r_out.highest_altitude     <= stats.highest_altitude;
            r_out.top_airspeed_raw     <= stats.top_airspeed_raw;
            r_out.fuel_flow_total      <= stats.fuel_flow_total;
            r_out.fuel_sample_count    <= stats.fuel_sample_count;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule
`default_nettype wire

FILE: rtl/fee_detector.sv
`default_nettype none
module fee_detector (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  fee_pkg::t_step_ctl             i_ctl,
    input  wire [fee_pkg::RPM_W-1:0]       i_value,
    input  wire [fee_pkg::RPM_W-1:0]       i_thr,
    input  wire [fee_pkg::RUN_W-1:0]       i_lookback,
    input  wire [fee_pkg::TIME_W-1:0]      i_now,
    output fee_pkg::t_det_res              o_res
);
    import fee_pkg::*;

    logic              r_phase, n_phase;
    logic [RUN_W-1:0]  r_count, n_count;
    logic [TIME_W-1:0] r_cand, n_cand;
    logic              qual;

    // off/landing looks for strictly below, on/takeoff for strictly above
    assign qual = r_phase ? (i_value < i_thr) : (i_value > i_thr);

    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_cand     = r_cand;
        o_res.ev   = EV_NONE;
        o_res.secs = '0;
        if (i_ctl.clr) begin
            n_phase = 1'b0;
            n_count = '0;
            n_cand  = '0;
        end else if (i_ctl.step) begin
            if (!qual) begin
                n_count = '0;
                n_cand  = '0;
            end else if (r_count == '0) begin
                n_cand  = i_now;
                n_count = RUN_W'(1);
            end else if (r_count >= i_lookback) begin
                o_res.ev   = r_phase ? EV_OFF : EV_ON;
                o_res.secs = r_cand;
                n_phase    = !r_phase;
                n_count    = '0;
                n_cand     = '0;
            end else begin
                n_count = r_count + RUN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_count <= '0;
            r_cand  <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_cand  <= n_cand;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/fee_stats.sv
`default_nettype none
module fee_stats (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  fee_pkg::t_step_ctl             i_ctl,
    input  fee_pkg::t_in                   i_sample,
    input  wire [fee_pkg::RPM_W-1:0]       i_rpm_thr,
    input  wire [fee_pkg::IAS_W-1:0]       i_air_thr,
    output fee_pkg::t_stats                o_stats
);
    import fee_pkg::*;

    t_stats            r_st, n_st;
    logic [IAS_W-1:0]  ias;
    logic              flying;
    logic              running;
    logic [SUM_W:0]    sum_ext;

    assign ias     = i_sample.airspeed_raw[AIR_W-1:IAS_SHIFT];
    assign flying  = ias > i_air_thr;
    assign running = i_sample.engine_rpm > i_rpm_thr;
    assign sum_ext = {1'b0, r_st.fuel_flow_total}
                   + {{(SUM_W+1-FUEL_W){1'b0}}, i_sample.fuel_flow_raw};

    always_comb begin
        n_st = r_st;
        if (i_ctl.clr) begin
            n_st.lowest_altitude   = ALT_LOW_INIT;
            n_st.highest_altitude  = ALT_HIGH_INIT;
            n_st.top_airspeed_raw  = '0;
            n_st.fuel_flow_total   = '0;
            n_st.fuel_sample_count = '0;
        end else if (i_ctl.step) begin
            if (flying) begin
                if (i_sample.altitude < r_st.lowest_altitude)
                    n_st.lowest_altitude = i_sample.altitude;
                if (i_sample.altitude > r_st.highest_altitude)
                    n_st.highest_altitude = i_sample.altitude;
                if (i_sample.airspeed_raw > r_st.top_airspeed_raw)
                    n_st.top_airspeed_raw = i_sample.airspeed_raw;
            end
            if (running) begin
                // carry out of the 48-bit sum means saturate
                n_st.fuel_flow_total = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
                if (r_st.fuel_sample_count != '1)
                    n_st.fuel_sample_count = r_st.fuel_sample_count + CNT_W'(1);
            end
        end
    end

    assign o_stats = n_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.lowest_altitude   <= ALT_LOW_INIT;
            r_st.highest_altitude  <= ALT_HIGH_INIT;
            r_st.top_airspeed_raw  <= '0;
            r_st.fuel_flow_total   <= '0;
            r_st.fuel_sample_count <= '0;
        end else begin
            r_st <= n_st;
        end
    end

endmodule
`default_nettype wire
